// ===== rtl/mps_pkg.sv =====
`timescale 1ns / 1ps
package mps_pkg;

  localparam int CORDIC_ITERATIONS = 16;
  localparam int CORDIC_TABLE_LEN = 24;
  localparam int CORDIC_STEPS = (CORDIC_ITERATIONS < CORDIC_TABLE_LEN) ?
                                CORDIC_ITERATIONS : CORDIC_TABLE_LEN;
  localparam int CIW = $clog2(CORDIC_TABLE_LEN);
  localparam int DIV_STEPS = 32;
  localparam int CNT_W = $clog2(DIV_STEPS);
  localparam int MAC_STEPS = 6;
  localparam int FIFO_DEPTH = 2;
  localparam int FPW = $clog2(FIFO_DEPTH);
  localparam int FCW = $clog2(FIFO_DEPTH + 1);

  localparam int MA_W = 32;
  localparam int MB_W = 19;
  localparam int PROD_W = MA_W + MB_W;
  localparam int ACC_W = 53;
  localparam int CX_W = 27;
  localparam int HEAD_MAX = 46080;
  localparam int HALF_TURN_Q16 = 180 * 65536;

  localparam logic [2:0] REG_H00_H01 = 3'd0;
  localparam logic [2:0] REG_H02_H10 = 3'd1;
  localparam logic [2:0] REG_H11_H12 = 3'd2;
  localparam logic [2:0] REG_H20_H21 = 3'd3;
  localparam logic [2:0] REG_H22 = 3'd4;
  localparam logic [2:0] REG_ALPHA = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DSET,
    ST_DIV,
    ST_DFIN,
    ST_BLEND,
    ST_SAVE,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [17:0]        su;
    logic [17:0]        sv;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
  } item_t;

  typedef struct packed {
    logic [63:0] h00_h01;
    logic [63:0] h02_h10;
    logic [63:0] h11_h12;
    logic [63:0] h20_h21;
    logic [31:0] h22;
    logic [16:0] alpha;
  } cfg_t;

  function automatic logic signed [CX_W-1:0] atan_deg(input logic [CIW-1:0] i);
    logic signed [CX_W-1:0] r;
    unique case (i)
      5'd0: r = 27'sd2949120;
      5'd1: r = 27'sd1740967;
      5'd2: r = 27'sd919879;
      5'd3: r = 27'sd466945;
      5'd4: r = 27'sd234379;
      5'd5: r = 27'sd117304;
      5'd6: r = 27'sd58666;
      5'd7: r = 27'sd29335;
      5'd8: r = 27'sd14668;
      5'd9: r = 27'sd7334;
      5'd10: r = 27'sd3667;
      5'd11: r = 27'sd1833;
      5'd12: r = 27'sd917;
      5'd13: r = 27'sd458;
      5'd14: r = 27'sd229;
      5'd15: r = 27'sd115;
      5'd16: r = 27'sd57;
      5'd17: r = 27'sd29;
      5'd18: r = 27'sd14;
      5'd19: r = 27'sd7;
      5'd20: r = 27'sd4;
      5'd21: r = 27'sd2;
      5'd22: r = 27'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/mps_if.sv =====
`timescale 1ns / 1ps
interface mps_in_if;
  logic        valid;
  logic        ready;
  logic        marker_found;
  logic [15:0] c0_x;
  logic [15:0] c0_y;
  logic [15:0] c1_x;
  logic [15:0] c1_y;
  logic [15:0] c2_x;
  logic [15:0] c2_y;
  logic [15:0] c3_x;
  logic [15:0] c3_y;
  modport source (output valid, marker_found, c0_x, c0_y, c1_x, c1_y, c2_x, c2_y,
                  c3_x, c3_y, input ready);
  modport sink (input valid, marker_found, c0_x, c0_y, c1_x, c1_y, c2_x, c2_y,
                c3_x, c3_y, output ready);
endinterface

interface mps_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] world_x;
  logic signed [31:0] world_y;
  logic signed [16:0] heading;
  modport source (output valid, world_x, world_y, heading, input ready);
  modport sink (input valid, world_x, world_y, heading, output ready);
endinterface

// ===== rtl/mps_front.sv =====
`timescale 1ns / 1ps
module mps_front import mps_pkg::*; (
  mps_in_if.sink in_i,
  input  logic   full_i,
  output logic   push_o,
  output item_t  item_o
);

  assign in_i.ready = !full_i;
  assign push_o = in_i.valid && !full_i && in_i.marker_found;

  assign item_o.su = 18'(in_i.c0_x) + 18'(in_i.c1_x) + 18'(in_i.c2_x) + 18'(in_i.c3_x);
  assign item_o.sv = 18'(in_i.c0_y) + 18'(in_i.c1_y) + 18'(in_i.c2_y) + 18'(in_i.c3_y);
  assign item_o.dx = $signed({1'b0, in_i.c1_x}) - $signed({1'b0, in_i.c0_x});
  assign item_o.dy = $signed({1'b0, in_i.c1_y}) - $signed({1'b0, in_i.c0_y});

endmodule

// ===== rtl/mps_fifo.sv =====
`timescale 1ns / 1ps
module mps_fifo import mps_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  item_t          mem_q [FIFO_DEPTH];
  logic [FPW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FCW-1:0] count_q;
  logic           do_pop;

  assign full_o  = (count_q == FCW'(FIFO_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == FPW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == FPW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== rtl/mps_back.sv =====
`timescale 1ns / 1ps
module mps_back import mps_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  item_valid_i,
  input  item_t item_i,
  output logic  item_pop_o,
  mps_out_if.source out_o
);

  state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q;
  item_t item_q;

  logic signed [MA_W-1:0] h00, h01, h02, h10, h11, h12, h20, h21, h22;
  logic [16:0] alpha_c, alpha_inv;

  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q [3];
  logic [2:0]               acc_tmp;
  logic [1:0]               acc_idx;

  logic [ACC_W-1:0] rem_q [2];
  logic [ACC_W-1:0] den_q [2];
  logic [31:0]      qsh_q [2];
  logic             neg_q [2];
  logic             sat_q [2];
  logic signed [ACC_W-1:0] w_fix;
  logic [ACC_W-1:0] d_abs;
  logic [ACC_W-1:0] n_abs [2];
  logic [ACC_W:0]   r2 [2];
  logic             ge [2];
  logic signed [31:0] dres [2];

  logic signed [CX_W-1:0] cx_q, cy_q, cz_q;
  logic                   czero_q;
  logic signed [CX_W-1:0] cx_sh, cy_sh, cz_rnd, dx_s, dy_s;
  logic                   y_pos;
  logic signed [16:0]     head_new;

  logic signed [31:0] nx_q, ny_q;
  logic signed [16:0] nh_q;
  logic signed [31:0] smooth_x_q, smooth_y_q;
  logic signed [16:0] smooth_h_q;
  logic               started_q;

  assign h00 = cfg_i.h00_h01[63:32];
  assign h01 = cfg_i.h00_h01[31:0];
  assign h02 = cfg_i.h02_h10[63:32];
  assign h10 = cfg_i.h02_h10[31:0];
  assign h11 = cfg_i.h11_h12[63:32];
  assign h12 = cfg_i.h11_h12[31:0];
  assign h20 = cfg_i.h20_h21[63:32];
  assign h21 = cfg_i.h20_h21[31:0];
  assign h22 = cfg_i.h22;
  assign alpha_c   = (cfg_i.alpha > 17'd65536) ? 17'd65536 : cfg_i.alpha;
  assign alpha_inv = 17'd65536 - alpha_c;

  assign acc_tmp = cnt_q[2:0] - 3'd1;
  assign acc_idx = acc_tmp[2:1];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == ST_MUL) begin
      unique case (cnt_q[2:0])
        3'd0: begin mul_a = h00; mul_b = $signed({1'b0, item_q.su}); end
        3'd1: begin mul_a = h01; mul_b = $signed({1'b0, item_q.sv}); end
        3'd2: begin mul_a = h10; mul_b = $signed({1'b0, item_q.su}); end
        3'd3: begin mul_a = h11; mul_b = $signed({1'b0, item_q.sv}); end
        3'd4: begin mul_a = h20; mul_b = $signed({1'b0, item_q.su}); end
        3'd5: begin mul_a = h21; mul_b = $signed({1'b0, item_q.sv}); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (state_q == ST_BLEND) begin
      unique case (cnt_q[2:0])
        3'd0: begin mul_a = nx_q; mul_b = $signed({2'b00, alpha_c}); end
        3'd1: begin mul_a = smooth_x_q; mul_b = $signed({2'b00, alpha_inv}); end
        3'd2: begin mul_a = ny_q; mul_b = $signed({2'b00, alpha_c}); end
        3'd3: begin mul_a = smooth_y_q; mul_b = $signed({2'b00, alpha_inv}); end
        3'd4: begin
          mul_a = {{(MA_W-17){nh_q[16]}}, nh_q};
          mul_b = $signed({2'b00, alpha_c});
        end
        3'd5: begin
          mul_a = {{(MA_W-17){smooth_h_q[16]}}, smooth_h_q};
          mul_b = $signed({2'b00, alpha_inv});
        end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  // Divider: magnitudes, the restoring step compare, and the result with its sign and overflow saturation.
  always_comb begin
    w_fix = (acc_q[2] == '0) ? ACC_W'(1) : acc_q[2];
    d_abs = w_fix[ACC_W-1] ? ACC_W'(-w_fix) : w_fix;
    for (int l = 0; l < 2; l++) begin
      n_abs[l] = acc_q[l][ACC_W-1] ? ACC_W'(-acc_q[l]) : acc_q[l];
      r2[l] = {rem_q[l], qsh_q[l][31]};
      ge[l] = (r2[l] >= {1'b0, den_q[l]});
      if (sat_q[l]) begin
        dres[l] = neg_q[l] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else if (neg_q[l]) begin
        dres[l] = (qsh_q[l] > 32'h8000_0000) ? 32'sh8000_0000 : -$signed(qsh_q[l]);
      end else begin
        dres[l] = qsh_q[l][31] ? 32'sh7fff_ffff : $signed(qsh_q[l]);
      end
    end
  end

  assign dx_s = {{(CX_W-25){item_q.dx[16]}}, item_q.dx, 8'b0};
  assign dy_s = {{(CX_W-25){item_q.dy[16]}}, item_q.dy, 8'b0};
  assign cx_sh = cx_q >>> cnt_q[CIW-1:0];
  assign cy_sh = cy_q >>> cnt_q[CIW-1:0];
  assign y_pos = !cy_q[CX_W-1] && (cy_q != '0);
  assign cz_rnd = (cz_q + CX_W'(128)) >>> 8;

  always_comb begin
    if (czero_q) begin
      head_new = '0;
    end else if (cz_rnd > $signed(CX_W'(HEAD_MAX))) begin
      head_new = 17'(HEAD_MAX);
    end else if (cz_rnd < -$signed(CX_W'(HEAD_MAX))) begin
      head_new = -$signed(17'(HEAD_MAX));
    end else begin
      head_new = cz_rnd[16:0];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (item_valid_i) state_d = ST_MUL;
      ST_MUL:   if (cnt_q == CNT_W'(MAC_STEPS)) state_d = ST_DSET;
      ST_DSET:  state_d = ST_DIV;
      ST_DIV:   if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = ST_DFIN;
      ST_DFIN:  state_d = started_q ? ST_BLEND : ST_OUT;
      ST_BLEND: if (cnt_q == CNT_W'(MAC_STEPS)) state_d = ST_SAVE;
      ST_SAVE:  state_d = ST_OUT;
      ST_OUT:   if (out_o.ready) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    item_pop_o    = (state_q == ST_IDLE);
    out_o.valid   = (state_q == ST_OUT);
    out_o.world_x = smooth_x_q;
    out_o.world_y = smooth_y_q;
    out_o.heading = smooth_h_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      started_q  <= 1'b0;
      smooth_x_q <= '0;
      smooth_y_q <= '0;
      smooth_h_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q != state_d) begin
        cnt_q <= '0;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (state_q == ST_DFIN && !started_q) begin
        started_q  <= 1'b1;
        smooth_x_q <= dres[0];
        smooth_y_q <= dres[1];
        smooth_h_q <= head_new;
      end
      if (state_q == ST_SAVE) begin
        smooth_x_q <= 32'(acc_q[0] >>> 16);
        smooth_y_q <= 32'(acc_q[1] >>> 16);
        smooth_h_q <= 17'(acc_q[2] >>> 16);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (state_q == ST_IDLE && item_valid_i) begin
      item_q   <= item_i;
      acc_q[0] <= {{(ACC_W-MA_W-6){h02[MA_W-1]}}, h02, 6'b0};
      acc_q[1] <= {{(ACC_W-MA_W-6){h12[MA_W-1]}}, h12, 6'b0};
      acc_q[2] <= {{(ACC_W-MA_W-6){h22[MA_W-1]}}, h22, 6'b0};
    end
    if ((state_q == ST_MUL || state_q == ST_BLEND) && cnt_q != '0) begin
      acc_q[acc_idx] <= acc_q[acc_idx] + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end
    if (state_q == ST_DSET) begin
      for (int l = 0; l < 2; l++) begin
        den_q[l] <= d_abs;
        neg_q[l] <= acc_q[l][ACC_W-1] ^ w_fix[ACC_W-1];
        sat_q[l] <= ({16'b0, n_abs[l]} >= {d_abs, 16'b0});
        rem_q[l] <= n_abs[l] >> 16;
        qsh_q[l] <= {n_abs[l][15:0], 16'b0};
      end
      czero_q <= (item_q.dx == '0) && (item_q.dy == '0);
      if (item_q.dx[16]) begin
        cx_q <= -dx_s;
        cy_q <= -dy_s;
        cz_q <= item_q.dy[16] ? -$signed(CX_W'(HALF_TURN_Q16)) : $signed(CX_W'(HALF_TURN_Q16));
      end else begin
        cx_q <= dx_s;
        cy_q <= dy_s;
        cz_q <= '0;
      end
    end
    if (state_q == ST_DIV) begin
      for (int l = 0; l < 2; l++) begin
        rem_q[l] <= ge[l] ? ACC_W'(r2[l] - {1'b0, den_q[l]}) : r2[l][ACC_W-1:0];
        qsh_q[l] <= {qsh_q[l][30:0], ge[l]};
      end
      if (cnt_q < CNT_W'(CORDIC_STEPS)) begin
        if (y_pos) begin
          cx_q <= cx_q + cy_sh;
          cy_q <= cy_q - cx_sh;
          cz_q <= cz_q + atan_deg(cnt_q[CIW-1:0]);
        end else begin
          cx_q <= cx_q - cy_sh;
          cy_q <= cy_q + cx_sh;
          cz_q <= cz_q - atan_deg(cnt_q[CIW-1:0]);
        end
      end
    end
    if (state_q == ST_DFIN) begin
      nx_q <= dres[0];
      ny_q <= dres[1];
      nh_q <= head_new;
      for (int l = 0; l < 3; l++) begin
        acc_q[l] <= ACC_W'(32768);
      end
    end
  end

endmodule

// ===== rtl/marker_pose_smoother_core.sv =====
`timescale 1ns / 1ps
// An accepted word with the marker present yields one result (the first sample loads the
// smoothing state directly and skips the blend). The back end takes one word at a time and
// no new word until its result is taken: homography products on one shared multiplier,
// then 32 restoring divider steps with the CORDIC in parallel, then the blending. Words
// without the marker are dropped at the input and never reach the back end.
// A two-entry queue lets the input side keep accepting while the back end works.
// Reset clears the smoothing state and loads the identity homography and alpha 0.25.
module marker_pose_smoother_core import mps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  mps_in_if.sink      in_i,
  mps_out_if.source   out_o
);

  cfg_t  cfg_q;
  logic  push, full, pop, q_valid;
  item_t push_item, q_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.h00_h01 <= 64'h0001_0000_0000_0000;
      cfg_q.h02_h10 <= '0;
      cfg_q.h11_h12 <= 64'h0001_0000_0000_0000;
      cfg_q.h20_h21 <= '0;
      cfg_q.h22     <= 32'h0001_0000;
      cfg_q.alpha   <= 17'd16384;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_H00_H01: cfg_q.h00_h01 <= cfg_data_i;
        REG_H02_H10: cfg_q.h02_h10 <= cfg_data_i;
        REG_H11_H12: cfg_q.h11_h12 <= cfg_data_i;
        REG_H20_H21: cfg_q.h20_h21 <= cfg_data_i;
        REG_H22:     cfg_q.h22 <= cfg_data_i[31:0];
        REG_ALPHA:   cfg_q.alpha <= cfg_data_i[16:0];
        default:     cfg_q <= cfg_q;
      endcase
    end
  end

  mps_front u_front (
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .item_o (push_item)
  );

  mps_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  mps_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (q_valid),
    .item_i       (q_item),
    .item_pop_o   (pop),
    .out_o        (out_o)
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full) else $error("queue written while full");

  a_absent_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && !in_i.marker_found) |-> !push)
    else $error("word without marker entered the queue");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && q_valid) |=> !pop) else $error("back end took a second word while busy");

endmodule
